// ----- hdl/eus_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package eus_pkg;

    localparam logic [1:0] KIND_PASS   = 2'd0;
    localparam logic [1:0] KIND_DING   = 2'd1;
    localparam logic [1:0] KIND_REJECT = 2'd2;

    localparam logic REQ_ADD  = 1'b0;
    localparam logic REQ_TICK = 1'b1;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_ADD,
        ST_ADD_RD,
        ST_ADD_CMP,
        ST_ADD_SHIFT,
        ST_ADD_PUT,
        ST_REJECT,
        ST_TICK,
        ST_TICK_EMPTY,
        ST_START,
        ST_MOVE,
        ST_MOVE_CMP,
        ST_DING,
        ST_PASS,
        ST_SKIP,
        ST_SKIP_CMP,
        ST_SKIP_INC,
        ST_END
    } step_t;

    typedef enum logic [3:0] {
        A_NONE,
        A_ACCEPT,
        A_SHIFT,
        A_PUT,
        A_REJECT,
        A_START,
        A_DING,
        A_PASS,
        A_CLR_MOVING,
        A_IDX_INC,
        A_END
    } act_t;

    typedef enum logic [1:0] {
        RD_NONE,
        RD_PTR_M1,
        RD_IDX,
        RD_LAST
    } rdsel_t;

    typedef enum logic [3:0] {
        C_NONE,
        C_ALWAYS,
        C_NO_ACCEPT,
        C_IS_TICK,
        C_REJECT,
        C_PTR_ZERO,
        C_RD_LE_FLOOR,
        C_ACTIVE,
        C_COUNT_ZERO,
        C_NOT_MOVING,
        C_CAR_LT_RD,
        C_IDX_GE_COUNT,
        C_RD_GT_CAR
    } cond_t;

    typedef struct packed {
        act_t   act;
        rdsel_t rd_sel;
        cond_t  cond;
        step_t  target;
    } ctrl_t;

    // control store: jump to target when cond holds, else fall through
    function automatic ctrl_t ucode(input step_t s);
        ctrl_t c;
        case (s)
            ST_IDLE:       c = '{A_ACCEPT,     RD_NONE,   C_NO_ACCEPT,    ST_IDLE};
            ST_DISPATCH:   c = '{A_NONE,       RD_NONE,   C_IS_TICK,      ST_TICK};
            ST_ADD:        c = '{A_NONE,       RD_NONE,   C_REJECT,       ST_REJECT};
            ST_ADD_RD:     c = '{A_NONE,       RD_PTR_M1, C_PTR_ZERO,     ST_ADD_PUT};
            ST_ADD_CMP:    c = '{A_NONE,       RD_PTR_M1, C_RD_LE_FLOOR,  ST_ADD_PUT};
            ST_ADD_SHIFT:  c = '{A_SHIFT,      RD_NONE,   C_ALWAYS,       ST_ADD_RD};
            ST_ADD_PUT:    c = '{A_PUT,        RD_NONE,   C_ALWAYS,       ST_IDLE};
            ST_REJECT:     c = '{A_REJECT,     RD_NONE,   C_ALWAYS,       ST_IDLE};
            ST_TICK:       c = '{A_NONE,       RD_NONE,   C_ACTIVE,       ST_MOVE};
            ST_TICK_EMPTY: c = '{A_NONE,       RD_NONE,   C_COUNT_ZERO,   ST_IDLE};
            ST_START:      c = '{A_START,      RD_NONE,   C_NONE,         ST_IDLE};
            ST_MOVE:       c = '{A_NONE,       RD_IDX,    C_NOT_MOVING,   ST_SKIP};
            ST_MOVE_CMP:   c = '{A_NONE,       RD_LAST,   C_CAR_LT_RD,    ST_PASS};
            ST_DING:       c = '{A_DING,       RD_LAST,   C_ALWAYS,       ST_IDLE};
            ST_PASS:       c = '{A_PASS,       RD_NONE,   C_ALWAYS,       ST_IDLE};
            ST_SKIP:       c = '{A_CLR_MOVING, RD_IDX,    C_IDX_GE_COUNT, ST_END};
            ST_SKIP_CMP:   c = '{A_NONE,       RD_NONE,   C_RD_GT_CAR,    ST_PASS};
            ST_SKIP_INC:   c = '{A_IDX_INC,    RD_NONE,   C_ALWAYS,       ST_SKIP};
            ST_END:        c = '{A_END,        RD_NONE,   C_ALWAYS,       ST_IDLE};
            default:       c = '{A_NONE,       RD_NONE,   C_ALWAYS,       ST_IDLE};
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

// ----- hdl/elevator_upward_sweep.sv -----
`timescale 1ns / 1ps
`default_nettype none
// channel   dir  tdata            tuser           tlast
// s_axis    in   floor [7:0]      req_type [0]    -
// m_axis    out  floor_shown[7:0] kind [1:0]      last
//
// An add shifts each stored stop that lies above the new floor up one slot
// before it stores the new floor; a rejected add stores nothing.
// A tick reads each stop it skips in turn, through the single read port
// of the stop RAM and its registered read.
// The next transfer in is taken once the sequencer is back in idle; a result
// waits in the output register, and a later result stalls its step until taken.
// Reset is asynchronous, active low; the stop RAM needs no clearing.

module elevator_upward_sweep #(
    parameter int MAX_STOPS  = 64,
    parameter int FLOOR_BITS = 8
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       s_axis_tvalid,
    output logic            s_axis_tready,
    input  wire logic [7:0] s_axis_tdata,   // floor[7:0]
    input  wire logic       s_axis_tuser,   // req_type[0]
    output logic            m_axis_tvalid,
    input  wire logic       m_axis_tready,
    output logic      [7:0] m_axis_tdata,   // floor_shown[7:0]
    output logic      [1:0] m_axis_tuser,   // kind[1:0]
    output logic            m_axis_tlast
);

    import eus_pkg::*;

    localparam int AW = $clog2(MAX_STOPS);
    localparam int CW = $clog2(MAX_STOPS + 1);

    step_t                 step_reg, step_next;
    logic [CW-1:0]         count_reg, count_next;
    logic [CW-1:0]         idx_reg, idx_next;
    logic [CW-1:0]         ptr_reg, ptr_next;
    logic [FLOOR_BITS-1:0] car_reg, car_next;
    logic                  moving_reg, moving_next;
    logic                  active_reg, active_next;
    logic                  type_reg, type_next;
    logic [FLOOR_BITS-1:0] floor_reg, floor_next;
    logic                  out_valid_reg, out_valid_next;
    logic [1:0]            out_kind_reg, out_kind_next;
    logic [7:0]            out_floor_reg, out_floor_next;
    logic                  out_last_reg, out_last_next;

    ctrl_t                 cw;
    logic                  accept;
    logic                  emit;
    logic                  stall;
    logic                  cond_true;
    logic [CW-1:0]         ptr_m1;
    logic [CW-1:0]         last_idx;
    logic                  ram_we;
    logic [AW-1:0]         ram_waddr;
    logic [FLOOR_BITS-1:0] ram_wdata;
    logic [AW-1:0]         ram_raddr;
    logic [FLOOR_BITS-1:0] rd_data;

    eus_ram #(
        .WIDTH(FLOOR_BITS),
        .DEPTH(MAX_STOPS)
    ) u_stops (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .raddr(ram_raddr),
        .rdata(rd_data)
    );

    assign cw            = ucode(step_reg);
    assign s_axis_tready = (step_reg == ST_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign emit          = (cw.act == A_REJECT) || (cw.act == A_DING) || (cw.act == A_PASS);
    assign stall         = emit && out_valid_reg && !m_axis_tready;
    assign ptr_m1        = ptr_reg - CW'(1);
    assign last_idx      = count_reg - CW'(1);

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_floor_reg;
    assign m_axis_tuser  = out_kind_reg;
    assign m_axis_tlast  = out_last_reg;

    always_comb
    begin
        case (cw.rd_sel)
            RD_PTR_M1: ram_raddr = ptr_m1[AW-1:0];
            RD_IDX:    ram_raddr = idx_reg[AW-1:0];
            RD_LAST:   ram_raddr = last_idx[AW-1:0];
            default:   ram_raddr = ptr_reg[AW-1:0];
        endcase
    end

    assign ram_we    = (cw.act == A_SHIFT) || (cw.act == A_PUT);
    assign ram_waddr = ptr_reg[AW-1:0];
    assign ram_wdata = (cw.act == A_SHIFT) ? rd_data : floor_reg;

    always_comb
    begin
        case (cw.cond)
            C_ALWAYS:       cond_true = 1'b1;
            C_NO_ACCEPT:    cond_true = !accept;
            C_IS_TICK:      cond_true = (type_reg == REQ_TICK);
            C_REJECT:       cond_true = active_reg || (count_reg == CW'(MAX_STOPS));
            C_PTR_ZERO:     cond_true = (ptr_reg == '0);
            C_RD_LE_FLOOR:  cond_true = (rd_data <= floor_reg);
            C_ACTIVE:       cond_true = active_reg;
            C_COUNT_ZERO:   cond_true = (count_reg == '0);
            C_NOT_MOVING:   cond_true = !moving_reg;
            C_CAR_LT_RD:    cond_true = (car_reg < rd_data);
            C_IDX_GE_COUNT: cond_true = (idx_reg >= count_reg);
            C_RD_GT_CAR:    cond_true = (rd_data > car_reg);
            default:        cond_true = 1'b0;
        endcase
    end

    always_comb
    begin
        step_next      = step_reg;
        count_next     = count_reg;
        idx_next       = idx_reg;
        ptr_next       = ptr_reg;
        car_next       = car_reg;
        moving_next    = moving_reg;
        active_next    = active_reg;
        type_next      = type_reg;
        floor_next     = floor_reg;
        out_valid_next = out_valid_reg;
        out_kind_next  = out_kind_reg;
        out_floor_next = out_floor_reg;
        out_last_next  = out_last_reg;

        if (out_valid_reg && m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end

        if (!stall)
        begin
            if (cond_true)
            begin
                step_next = cw.target;
            end
            else
            begin
                step_next = step_t'(step_reg + 5'd1);
            end

            case (cw.act)
                A_ACCEPT:
                begin
                    if (accept)
                    begin
                        type_next  = s_axis_tuser;
                        floor_next = FLOOR_BITS'(s_axis_tdata);
                        ptr_next   = count_reg;
                    end
                end
                A_SHIFT:
                begin
                    ptr_next = ptr_m1;
                end
                A_PUT:
                begin
                    count_next = count_reg + CW'(1);
                end
                A_REJECT:
                begin
                    out_valid_next = 1'b1;
                    out_kind_next  = KIND_REJECT;
                    out_floor_next = 8'(floor_reg);
                    out_last_next  = 1'b0;
                end
                A_START:
                begin
                    active_next = 1'b1;
                    idx_next    = '0;
                    car_next    = '0;
                    moving_next = 1'b0;
                end
                A_DING:
                begin
                    out_valid_next = 1'b1;
                    out_kind_next  = KIND_DING;
                    out_floor_next = 8'(car_reg);
                    out_last_next  = (rd_data <= car_reg);
                    moving_next    = 1'b0;
                    if (rd_data <= car_reg)
                    begin
                        count_next  = '0;
                        idx_next    = '0;
                        car_next    = '0;
                        active_next = 1'b0;
                    end
                    else
                    begin
                        idx_next = idx_reg + CW'(1);
                    end
                end
                A_PASS:
                begin
                    out_valid_next = 1'b1;
                    out_kind_next  = KIND_PASS;
                    out_floor_next = 8'(car_reg);
                    out_last_next  = 1'b0;
                    car_next       = car_reg + FLOOR_BITS'(1);
                    moving_next    = 1'b1;
                end
                A_CLR_MOVING:
                begin
                    moving_next = 1'b0;
                end
                A_IDX_INC:
                begin
                    idx_next = idx_reg + CW'(1);
                end
                A_END:
                begin
                    count_next  = '0;
                    idx_next    = '0;
                    car_next    = '0;
                    moving_next = 1'b0;
                    active_next = 1'b0;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg      <= ST_IDLE;
            count_reg     <= '0;
            idx_reg       <= '0;
            car_reg       <= '0;
            moving_reg    <= 1'b0;
            active_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            step_reg      <= step_next;
            count_reg     <= count_next;
            idx_reg       <= idx_next;
            car_reg       <= car_next;
            moving_reg    <= moving_next;
            active_reg    <= active_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ptr_reg       <= ptr_next;
        type_reg      <= type_next;
        floor_reg     <= floor_next;
        out_kind_reg  <= out_kind_next;
        out_floor_reg <= out_floor_next;
        out_last_reg  <= out_last_next;
    end

endmodule

`default_nettype wire

// ----- hdl/eus_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none

module eus_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ----- hdl/eus_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none

module eus_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       s_axis_tvalid,
    input wire logic       s_axis_tready,
    input wire logic       m_axis_tvalid,
    input wire logic       m_axis_tready,
    input wire logic [7:0] m_axis_tdata,
    input wire logic [1:0] m_axis_tuser,
    input wire logic       m_axis_tlast
);

    import eus_pkg::*;

    // held result must not change until transferred
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)
            && $stable(m_axis_tlast))
        else $error("result changed while stalled");

    // last marks only the final ding of a round
    a_last_ding: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tlast |-> m_axis_tuser == KIND_DING)
        else $error("last on a non-ding result");

    // the sequencer is busy on the cycle after taking an item
    a_busy_after_in: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input taken on back-to-back cycles");

    // no unused kind code ever leaves the block
    a_kind_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |->
            m_axis_tuser == KIND_PASS || m_axis_tuser == KIND_DING
            || m_axis_tuser == KIND_REJECT)
        else $error("bad result kind");

endmodule

bind elevator_upward_sweep eus_checker u_eus_checker (.*);

`default_nettype wire
